/* rtl/core/sca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, codes and constants of the size-class handle allocator.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int HANDLE_COUNT_DEF = 1024;
  localparam int SIZE_CLASSES_DEF = 16;
  localparam int HEADER_BYTES_DEF = 32;

  // Alignment is a power of two; sizes round up to a multiple of it.
  localparam int ALIGN_BYTES     = 8;
  localparam int MIN_CLASS_BYTES = 8;
  localparam int CACHE_MAX       = 2047;
  localparam int MEM_LIMIT_RST   = 1048576;

  localparam int HANDLE_W = 10;
  localparam int REQ_W    = 32;
  localparam int CLASS_W  = 5;
  localparam int CHARGE_W = 33;
  localparam int TOTAL_W  = 34;
  localparam int COUNT_W  = 11;
  localparam int CACHE_W  = 11;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_OVER_LIMIT = 3'd2,
    ST_NO_HANDLE  = 3'd3,
    ST_NOT_IN_USE = 3'd4
  } status_t;

  // Execution unit sequencing.
  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_READ  = 2'd1,
    S_EXEC  = 2'd2
  } back_state_t;

  // Decoded request handed from the front end to the execution unit.
  typedef struct packed {
    logic [1:0]          op;
    logic [REQ_W-1:0]    req;
    logic [HANDLE_W-1:0] handle;
    logic                zero;
    logic [CLASS_W-1:0]  cls;
    logic [CHARGE_W-1:0] charge;
  } cmd_t;

  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic [CHARGE_W-1:0] charge;
  } rec_t;

endpackage

/* rtl/core/sca_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_front
// Accepts requests, rounds the size and picks its class and charge.
// ----------------------------------------------------------------------------
module sca_front #(
  parameter int SIZE_CLASSES = sca_pkg::SIZE_CLASSES_DEF,
  parameter int HEADER_BYTES = sca_pkg::HEADER_BYTES_DEF
) (
  input  logic                         in_valid,
  input  logic [1:0]                   in_op,
  input  logic [sca_pkg::REQ_W-1:0]    in_req,
  input  logic [sca_pkg::HANDLE_W-1:0] in_handle,
  input  logic                         q_full,
  input  logic                         busy,
  output logic                         in_ready,
  output logic                         q_push,
  output sca_pkg::cmd_t                q_data
);

  localparam logic [sca_pkg::CHARGE_W-1:0] ALIGN_M1 =
    sca_pkg::CHARGE_W'(sca_pkg::ALIGN_BYTES - 1);

  logic [sca_pkg::CHARGE_W-1:0] rounded;
  logic [sca_pkg::CHARGE_W-1:0] chunk;
  logic [sca_pkg::CLASS_W-1:0]  cls;
  logic                         found;

  assign rounded = ({1'b0, in_req} + ALIGN_M1) & ~ALIGN_M1;

  always_comb begin
    found = 1'b0;
    cls   = sca_pkg::CLASS_W'(SIZE_CLASSES);
    chunk = '0;
    for (int i = 0; i < SIZE_CLASSES; i++) begin
      if (!found && (rounded <= (sca_pkg::CHARGE_W'(sca_pkg::MIN_CLASS_BYTES) << i))) begin
        found = 1'b1;
        cls   = sca_pkg::CLASS_W'(i);
        chunk = sca_pkg::CHARGE_W'(sca_pkg::MIN_CLASS_BYTES) << i;
      end
    end
  end

  assign in_ready = !q_full && !busy;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_data        = '0;
    q_data.op     = in_op;
    q_data.req    = in_req;
    q_data.handle = in_handle;
    q_data.zero   = (in_req == '0);
    q_data.cls    = cls;
    q_data.charge = found ? (chunk + sca_pkg::CHARGE_W'(HEADER_BYTES)) : rounded;
  end

endmodule

/* rtl/core/sca_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_queue
// Two-entry queue of decoded requests between front end and execution unit.
// ----------------------------------------------------------------------------
module sca_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sca_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output sca_pkg::cmd_t head
);

  sca_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/sca_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_back
// Execution unit: reads handle stack and records, then updates the books.
// ----------------------------------------------------------------------------
module sca_back #(
  parameter int HANDLE_COUNT = sca_pkg::HANDLE_COUNT_DEF,
  parameter int SIZE_CLASSES = sca_pkg::SIZE_CLASSES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [31:0]                  cfg_wr_data,
  input  logic                         q_not_empty,
  input  sca_pkg::cmd_t                q_head,
  output logic                         q_pop,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [sca_pkg::HANDLE_W-1:0] out_handle,
  output logic [sca_pkg::CLASS_W-1:0]  out_cls,
  output logic [sca_pkg::CHARGE_W-1:0] out_charge,
  output logic                         out_reused,
  output logic                         out_live,
  output logic [sca_pkg::TOTAL_W-1:0]  out_used,
  output logic [sca_pkg::TOTAL_W-1:0]  out_peak,
  output logic [sca_pkg::COUNT_W-1:0]  out_count
);

  localparam int HIW = $clog2(HANDLE_COUNT);
  localparam int DW  = $clog2(HANDLE_COUNT + 1);
  localparam int CIW = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int TW  = sca_pkg::TOTAL_W;

  sca_pkg::back_state_t state_r, state_nxt;

  // Memories
  logic [HIW-1:0]  stack_mem [HANDLE_COUNT];
  logic            inuse_mem [HANDLE_COUNT];
  sca_pkg::rec_t   rec_mem   [HANDLE_COUNT];

  logic [HIW-1:0]  clr_idx_r;
  logic [DW-1:0]   depth_r;
  logic [DW-1:0]   min_r;
  logic [TW-1:0]   used_r, peak_r;
  logic [DW-1:0]   active_r;
  logic [31:0]     limit_r;
  logic [sca_pkg::CACHE_W-1:0] cache_r [SIZE_CLASSES];

  sca_pkg::cmd_t   cmd_r;
  logic            over_r;
  logic [TW-1:0]   sum_r;
  logic            top_rst_r;
  logic [HIW-1:0]  top_rst_val_r;
  logic [HIW-1:0]  stk_rd_r;
  logic            inuse_rd_r;
  sca_pkg::rec_t   rec_rd_r;

  logic            rd_en, ex_fire, clr_we;

  // Read side
  logic [DW-1:0]   dm1;
  logic [HIW-1:0]  stk_addr;
  logic [31:0]     qh_ext, ch_ext;
  logic [HIW-1:0]  q_hidx, c_hidx;
  logic            c_hbig;

  assign dm1      = depth_r - DW'(1);
  assign stk_addr = dm1[HIW-1:0];
  assign qh_ext   = 32'(q_head.handle);
  assign q_hidx   = qh_ext[HIW-1:0];
  assign ch_ext   = 32'(cmd_r.handle);
  assign c_hidx   = ch_ext[HIW-1:0];
  assign c_hbig   = (ch_ext >= 32'(HANDLE_COUNT));

  // FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sca_pkg::S_CLEAR: if (clr_idx_r == HIW'(HANDLE_COUNT - 1)) state_nxt = sca_pkg::S_READ;
      sca_pkg::S_READ:  if (q_not_empty) state_nxt = sca_pkg::S_EXEC;
      sca_pkg::S_EXEC:  if (!out_valid || out_ready) state_nxt = sca_pkg::S_READ;
      default: state_nxt = sca_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    rd_en   = (state_r == sca_pkg::S_READ) && q_not_empty;
    ex_fire = (state_r == sca_pkg::S_EXEC) && (!out_valid || out_ready);
    clr_we  = (state_r == sca_pkg::S_CLEAR);
    busy    = (state_r == sca_pkg::S_CLEAR);
  end

  assign q_pop = rd_en;

  // Execute
  logic [CIW-1:0]  acls_idx, rcls_idx;
  logic [HIW-1:0]  top_val;
  logic [sca_pkg::CACHE_W-1:0] acache, rcache;
  logic [TW:0]     rel_diff;
  logic [2:0]      res_status;
  logic [sca_pkg::HANDLE_W-1:0] res_handle;
  logic [sca_pkg::CLASS_W-1:0]  res_cls;
  logic [sca_pkg::CHARGE_W-1:0] res_charge;
  logic            res_reused, res_live;
  logic            do_alloc, do_release;
  logic [TW-1:0]   used_nxt, peak_nxt;
  logic [DW-1:0]   active_nxt;
  logic [31:0]     top_ext, act_ext;

  assign top_val  = top_rst_r ? top_rst_val_r : stk_rd_r;
  assign top_ext  = 32'(top_val);
  assign acls_idx = cmd_r.cls[CIW-1:0];
  assign rcls_idx = rec_rd_r.cls[CIW-1:0];
  assign acache   = cache_r[acls_idx];
  assign rcache   = cache_r[rcls_idx];
  assign rel_diff = {1'b0, used_r} - (TW + 1)'(rec_rd_r.charge);

  always_comb begin
    res_status = sca_pkg::ST_OK;
    res_handle = cmd_r.handle;
    res_cls    = '0;
    res_charge = '0;
    res_reused = 1'b0;
    res_live   = 1'b0;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    unique case (cmd_r.op)
      sca_pkg::OP_ALLOC: begin
        res_handle = '0;
        priority if (cmd_r.zero) res_status = sca_pkg::ST_ZERO_SIZE;
        else if (over_r)         res_status = sca_pkg::ST_OVER_LIMIT;
        else if (depth_r == '0)  res_status = sca_pkg::ST_NO_HANDLE;
        else begin
          do_alloc   = 1'b1;
          res_handle = top_ext[sca_pkg::HANDLE_W-1:0];
          res_cls    = cmd_r.cls;
          res_charge = cmd_r.charge;
          res_live   = 1'b1;
          res_reused = (32'(cmd_r.cls) < 32'(SIZE_CLASSES)) && (acache != '0);
        end
      end
      sca_pkg::OP_RELEASE, sca_pkg::OP_QUERY: begin
        if (c_hbig || !inuse_rd_r) begin
          res_status = sca_pkg::ST_NOT_IN_USE;
        end else begin
          res_cls    = rec_rd_r.cls;
          res_charge = rec_rd_r.charge;
          res_live   = 1'b1;
          do_release = (cmd_r.op == sca_pkg::OP_RELEASE);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    used_nxt   = used_r;
    peak_nxt   = peak_r;
    active_nxt = active_r;
    if (do_alloc) begin
      used_nxt   = sum_r;
      peak_nxt   = (sum_r > peak_r) ? sum_r : peak_r;
      active_nxt = active_r + DW'(1);
    end else if (do_release) begin
      used_nxt   = rel_diff[TW] ? '0 : rel_diff[TW-1:0];
      active_nxt = (active_r != '0) ? active_r - DW'(1) : active_r;
    end
  end

  assign act_ext = 32'(active_nxt);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sca_pkg::S_CLEAR;
      clr_idx_r <= '0;
      depth_r   <= DW'(HANDLE_COUNT);
      min_r     <= DW'(HANDLE_COUNT);
      used_r    <= '0;
      peak_r    <= '0;
      active_r  <= '0;
      limit_r   <= 32'(sca_pkg::MEM_LIMIT_RST);
      out_valid <= 1'b0;
      for (int i = 0; i < SIZE_CLASSES; i++) cache_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_we) clr_idx_r <= clr_idx_r + HIW'(1);
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (ex_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (ex_fire) begin
        used_r   <= used_nxt;
        peak_r   <= peak_nxt;
        active_r <= active_nxt;
        if (do_alloc) begin
          depth_r <= dm1;
          if (dm1 < min_r) min_r <= dm1;
          if (res_reused) cache_r[acls_idx] <= acache - sca_pkg::CACHE_W'(1);
        end
        if (do_release) begin
          if (depth_r < DW'(HANDLE_COUNT)) depth_r <= depth_r + DW'(1);
          if ((32'(rec_rd_r.cls) < 32'(SIZE_CLASSES)) &&
              (rcache < sca_pkg::CACHE_W'(sca_pkg::CACHE_MAX))) begin
            cache_r[rcls_idx] <= rcache + sca_pkg::CACHE_W'(1);
          end
        end
      end
    end
  end

  // Read stage registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmd_r         <= q_head;
      over_r        <= ({3'b0, used_r} + (TW + 3)'(q_head.req)) > (TW + 3)'(limit_r);
      sum_r         <= used_r + TW'(q_head.charge);
      top_rst_r     <= (dm1 < min_r);
      top_rst_val_r <= HIW'(HANDLE_COUNT - 1) - stk_addr;
      stk_rd_r      <= stack_mem[stk_addr];
      inuse_rd_r    <= inuse_mem[q_hidx];
      rec_rd_r      <= rec_mem[q_hidx];
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (ex_fire && do_release && (depth_r < DW'(HANDLE_COUNT))) begin
      stack_mem[depth_r[HIW-1:0]] <= c_hidx;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we) inuse_mem[clr_idx_r] <= 1'b0;
    else if (ex_fire && do_alloc) inuse_mem[top_val] <= 1'b1;
    else if (ex_fire && do_release) inuse_mem[c_hidx] <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ex_fire && do_alloc) begin
      rec_mem[top_val] <= '{cls: cmd_r.cls, charge: cmd_r.charge};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_status <= res_status;
      out_handle <= res_handle;
      out_cls    <= res_cls;
      out_charge <= res_charge;
      out_reused <= res_reused;
      out_live   <= res_live;
      out_used   <= used_nxt;
      out_peak   <= peak_nxt;
      out_count  <= act_ext[sca_pkg::COUNT_W-1:0];
    end
  end

endmodule

/* rtl/core/size_class_handle_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_handle_allocator_core
// Handle-based size-class allocator bookkeeping with usage accounting.
// ----------------------------------------------------------------------------
// Each request (allocate, release or query) passes through the execution unit
// in a read step, which reads the handle stack, use flags and handle records,
// and then an execute step, which updates them and loads the result register.
// A two-entry queue lets the front end keep accepting while the execution unit
// works or the result waits. After reset the execution unit clears all
// HANDLE_COUNT (1024 by default) handle use flags in turn; no request is
// accepted during that time, while memory_limit writes are taken as usual.
module size_class_handle_allocator_core #(
  parameter int HANDLE_COUNT = sca_pkg::HANDLE_COUNT_DEF,
  parameter int SIZE_CLASSES = sca_pkg::SIZE_CLASSES_DEF,
  parameter int HEADER_BYTES = sca_pkg::HEADER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,   // memory_limit
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,      // operation
  input  logic [47:0]  in_tdata,      // request_bytes[31:0], handle[41:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [2:0]   out_tuser,     // status
  // granted_handle[9:0], size_class[14:10], charged_bytes[47:15],
  // chunk_reused[48], handle_live[49], used_total[83:50],
  // peak_total[117:84], live_count[128:118]
  output logic [135:0] out_tdata
);

  logic          q_push, q_pop, q_full, q_not_empty, busy;
  sca_pkg::cmd_t q_in, q_head;

  logic [sca_pkg::HANDLE_W-1:0] o_handle;
  logic [sca_pkg::CLASS_W-1:0]  o_cls;
  logic [sca_pkg::CHARGE_W-1:0] o_charge;
  logic                         o_reused, o_live;
  logic [sca_pkg::TOTAL_W-1:0]  o_used, o_peak;
  logic [sca_pkg::COUNT_W-1:0]  o_count;

  sca_front #(
    .SIZE_CLASSES (SIZE_CLASSES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_req    (in_tdata[31:0]),
    .in_handle (in_tdata[41:32]),
    .q_full    (q_full),
    .busy      (busy),
    .in_ready  (in_tready),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  sca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sca_back #(
    .HANDLE_COUNT (HANDLE_COUNT),
    .SIZE_CLASSES (SIZE_CLASSES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .busy        (busy),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_handle  (o_handle),
    .out_cls     (o_cls),
    .out_charge  (o_charge),
    .out_reused  (o_reused),
    .out_live    (o_live),
    .out_used    (o_used),
    .out_peak    (o_peak),
    .out_count   (o_count)
  );

  assign out_tdata = {7'b0, o_count, o_peak, o_used, o_live, o_reused,
                      o_charge, o_cls, o_handle};

endmodule

/* rtl/core/sca_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks of the size-class handle allocator.
// ----------------------------------------------------------------------------
module sca_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [2:0]   out_tuser,
  input logic [135:0] out_tdata
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // The peak never falls below current usage.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[117:84] >= out_tdata[83:50]))
    else $error("peak below used");

  // A rejected allocate gives no handle and no live mark.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == sca_pkg::ST_ZERO_SIZE ||
                   out_tuser == sca_pkg::ST_OVER_LIMIT ||
                   out_tuser == sca_pkg::ST_NO_HANDLE)
    |-> (out_tdata[9:0] == 10'd0) && !out_tdata[49])
    else $error("rejected allocate reports a handle");

endmodule

bind size_class_handle_allocator_core sca_checker u_sca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
